### src/feh_pkg.sv
package feh_pkg;

   // Grid geometry defaults
   localparam int DEF_MAX_COLS     = 128;
   localparam int DEF_MAX_ROWS     = 128;
   localparam int DEF_PALETTE_SIZE = 37;

   // Field widths
   localparam int HEAT_W   = 6;
   localparam int CSR_W    = 8;
   localparam int ADDR_W   = 7;
   localparam int COLOUR_W = 8;

   // Configuration registers
   localparam logic [CSR_W-1:0] COLS_RESET = 8'd128;
   localparam logic [CSR_W-1:0] ROWS_RESET = 8'd128;

   typedef enum logic [0:0] {
      CSR_COLS_IN_USE = 1'b0,
      CSR_ROWS_IN_USE = 1'b1
   } csr_index_type;

   // Operation codes; the unused code behaves as a read.
   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_SPREAD = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // Drift codes carried in the random bits
   localparam logic [1:0] DRIFT_LEFT  = 2'd0;
   localparam logic [1:0] DRIFT_RIGHT = 2'd3;

   // Palette, packed as {blue, green, red}
   localparam int TABLE_LEN = 37;
   localparam logic [3*COLOUR_W-1:0] PALETTE [TABLE_LEN] = '{
      24'h070707, 24'h07071F, 24'h070F2F, 24'h070F47,
      24'h071757, 24'h071F67, 24'h071F77, 24'h07278F,
      24'h072F9F, 24'h073FAF, 24'h0747BF, 24'h0747C7,
      24'h074FDF, 24'h0757DF, 24'h0757DF, 24'h075FD7,
      24'h075FD7, 24'h0F67D7, 24'h0F6FCF, 24'h0F77CF,
      24'h0F7FCF, 24'h1787CF, 24'h1787C7, 24'h178FC7,
      24'h1F97C7, 24'h1F9FBF, 24'h1F9FBF, 24'h27A7BF,
      24'h27A7BF, 24'h2FAFBF, 24'h2FAFB7, 24'h2FB7B7,
      24'h37B7B7, 24'h6FCFCF, 24'h9FDFDF, 24'hC7EFEF,
      24'hFFFFFF
   };

   // Heat beyond the table saturates at the last (white) entry.
   function automatic logic [3*COLOUR_W-1:0] palette_colour(input logic [HEAT_W-1:0] heat);
      logic [3*COLOUR_W-1:0] colour;
      if (32'(heat) < TABLE_LEN) begin
         colour = PALETTE[heat];
      end else begin
         colour = PALETTE[TABLE_LEN-1];
      end
      return colour;
   endfunction

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch request and launch grid read
      logic lookup;     // grid data valid: load result, write neighbour
      logic sweep_en;   // write one grid cell of the clearing pass
      logic sweep_hot;  // clearing pass lays down the fire source row
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_init;
      logic sweep_last;
   } dp_status_type;

endpackage

### src/fire_effect_heat_grid_top.sv
// Fire effect heat grid. The block holds a MAX_COLS x MAX_ROWS grid of heat
// indexes in a single on-chip memory and answers every request transfer with
// exactly one response transfer: the heat of the addressed cell as it stood
// before the request acted, together with that heat's palette colour (blue,
// green, red). A read or spread request reads the grid memory as it is
// taken and then, in the lookup state, decides and writes the neighbour
// above; the next request is taken only after the lookup state and when
// the response side keeps up. An initialize request runs a clearing pass
// through the memory, one cell per cycle, laying down the hottest index
// along the last row in use. The same pass, without the hot row, runs
// after reset, and no request is taken until it has finished. Configuration
// writes (columns in use, rows in use) are accepted at any time but must
// only be issued while the block is idle. A response still waiting in the
// output register holds off the next request transfer until the response
// transfer has taken place.
module fire_effect_heat_grid_top
   import feh_pkg::*;
#(
   parameter int MAX_COLS     = DEF_MAX_COLS,
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   // Configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   // Request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [ADDR_W-1:0]   req_col,
   input  logic [ADDR_W-1:0]   req_row,
   input  logic [1:0]          req_random_bits,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HEAT_W-1:0]   rsp_heat,
   output logic [COLOUR_W-1:0] rsp_blue,
   output logic [COLOUR_W-1:0] rsp_green,
   output logic [COLOUR_W-1:0] rsp_red
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Registers are plain flops, so a configuration transfer never stalls.
   assign csr_ready = 1'b1;

   // The controller sequences the grid accesses and owns the handshakes.
   feh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the grid memory, the settings and the result register.
   feh_datapath #(
      .MAX_COLS     (MAX_COLS),
      .MAX_ROWS     (MAX_ROWS),
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_operation   (req_operation),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_random_bits (req_random_bits),
      .cmd             (cmd),
      .status          (status),
      .rsp_heat        (rsp_heat),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red)
   );

endmodule

### src/feh_datapath.sv
module feh_datapath
   import feh_pkg::*;
#(
   parameter int MAX_COLS     = DEF_MAX_COLS,
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr,
   input  logic [0:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   input  logic [1:0]          req_operation,
   input  logic [ADDR_W-1:0]   req_col,
   input  logic [ADDR_W-1:0]   req_row,
   input  logic [1:0]          req_random_bits,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   output logic [HEAT_W-1:0]   rsp_heat,
   output logic [COLOUR_W-1:0] rsp_blue,
   output logic [COLOUR_W-1:0] rsp_green,
   output logic [COLOUR_W-1:0] rsp_red
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam logic [HEAT_W-1:0] HOT = HEAT_W'(PALETTE_SIZE - 1);

   logic [CSR_W-1:0]    cols_ff, cols_in;
   logic [CSR_W-1:0]    rows_ff, rows_in;
   logic [CNW-1:0]      cols_eff;
   logic [RNW-1:0]      rows_eff;

   logic [1:0]          op_ff;
   logic [ADDR_W-1:0]   col_ff;
   logic [ADDR_W-1:0]   row_ff;
   logic [1:0]          bits_ff;

   logic [HEAT_W-1:0]   grid_mem [DEPTH];
   logic [HEAT_W-1:0]   rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [HEAT_W-1:0]   wr_data;

   logic [CW-1:0]       sw_col_ff, sw_col_in;
   logic [RW-1:0]       sw_row_ff, sw_row_in;
   logic                sw_col_last;
   logic                sw_row_last;
   logic [HEAT_W-1:0]   sw_data;

   logic                in_grid;
   logic [HEAT_W-1:0]   heat;
   logic                spread_ok;
   logic [CW-1:0]       dx;
   logic [HEAT_W-1:0]   spread_data;

   logic [HEAT_W-1:0]   heat_ff;
   logic [COLOUR_W-1:0] blue_ff, green_ff, red_ff;

   // Configuration registers
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_COLS_IN_USE: cols_in = csr_data;
            CSR_ROWS_IN_USE: rows_in = csr_data;
            default:         cols_in = cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Out-of-range settings are clamped to the usable span.
   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CNW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CNW'(MAX_COLS);
      end else begin
         cols_eff = CNW'(cols_ff);
      end
      if (32'(rows_ff) < 2) begin
         rows_eff = RNW'(2);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RNW'(MAX_ROWS);
      end else begin
         rows_eff = RNW'(rows_ff);
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         col_ff  <= req_col;
         row_ff  <= req_row;
         bits_ff <= req_random_bits;
      end
   end

   // Clearing pass counters
   assign sw_col_last = (sw_col_ff == CW'(MAX_COLS - 1));
   assign sw_row_last = (sw_row_ff == RW'(MAX_ROWS - 1));

   always_comb begin
      sw_col_in = sw_col_ff;
      sw_row_in = sw_row_ff;
      if (cmd.sweep_en) begin
         if (sw_col_last) begin
            sw_col_in = '0;
            sw_row_in = sw_row_last ? '0 : sw_row_ff + RW'(1);
         end else begin
            sw_col_in = sw_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_col_ff <= '0;
         sw_row_ff <= '0;
      end else begin
         sw_col_ff <= sw_col_in;
         sw_row_ff <= sw_row_in;
      end
   end

   assign sw_data = (cmd.sweep_hot && (32'(sw_row_ff) == 32'(rows_eff) - 1)
                     && (32'(sw_col_ff) < 32'(cols_eff))) ? HOT : '0;

   // Spread decision on the cell just read
   always_comb begin
      in_grid   = (32'(col_ff) < MAX_COLS) && (32'(row_ff) < MAX_ROWS);
      heat      = in_grid ? rd_data_ff : '0;
      spread_ok = (op_ff == OP_SPREAD) && in_grid && (row_ff != '0)
                  && (32'(row_ff) < 32'(rows_eff)) && (32'(col_ff) < 32'(cols_eff));
      dx          = CW'(col_ff);
      spread_data = '0;
      if (heat != '0) begin
         spread_data = heat - HEAT_W'(bits_ff[0]);
         if (bits_ff == DRIFT_LEFT && col_ff != '0) begin
            dx = CW'(col_ff) - CW'(1);
         end else if (bits_ff == DRIFT_RIGHT && (32'(col_ff) + 1 < 32'(cols_eff))) begin
            dx = CW'(col_ff) + CW'(1);
         end
      end
   end

   // Grid memory port selection
   assign rd_addr = {RW'(req_row), CW'(req_col)};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {sw_row_ff, sw_col_ff};
      wr_data = sw_data;
      if (cmd.sweep_en) begin
         wr_en = 1'b1;
      end else if (cmd.lookup && spread_ok) begin
         wr_en   = 1'b1;
         wr_addr = {RW'(row_ff) - RW'(1), dx};
         wr_data = spread_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         heat_ff                      <= heat;
         {blue_ff, green_ff, red_ff}  <= palette_colour(heat);
      end
   end

   assign rsp_heat  = heat_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_green = green_ff;
   assign rsp_red   = red_ff;

   assign status.op_init    = (op_ff == OP_INIT);
   assign status.sweep_last = sw_col_last && sw_row_last;

endmodule

### src/feh_ctrl.sv
module feh_ctrl
   import feh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // A new request is taken in the idle state once the result slot is empty or emptying.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.capture   = accept;
      cmd.lookup    = (state_ff == ST_LOOKUP);
      cmd.sweep_en  = (state_ff == ST_CLEAR) || (state_ff == ST_SWEEP);
      cmd.sweep_hot = (state_ff == ST_SWEEP);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            state_in     = status.op_init ? ST_SWEEP : ST_IDLE;
         end
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/feh_checker.sv
module feh_checker
   import feh_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [1:0]          req_operation,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [HEAT_W-1:0]   rsp_heat,
   input logic [COLOUR_W-1:0] rsp_blue,
   input logic [COLOUR_W-1:0] rsp_green,
   input logic [COLOUR_W-1:0] rsp_red
);

   // A stalled response stays valid and keeps its heat and red value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heat) && $stable(rsp_red))
      else $error("response changed while stalled");

   // A request is never taken while an untaken response would be overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken over a pending response");

   // After a read or spread is taken, requests are held off while it is looked up, and the response then becomes valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation != OP_INIT) |=> !req_ready ##1 rsp_valid)
      else $error("response late for read or spread");

   // Cold cells show the darkest palette entry.
   a_cold_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_heat == '0) |->
         (rsp_blue == 8'h07) && (rsp_green == 8'h07) && (rsp_red == 8'h07))
      else $error("wrong colour for zero heat");

endmodule

bind fire_effect_heat_grid_top feh_checker u_feh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_heat      (rsp_heat),
   .rsp_blue      (rsp_blue),
   .rsp_green     (rsp_green),
   .rsp_red       (rsp_red)
);
